// File: rtl/mexp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg : shared constants and types for the modular exponentiation block
// Field widths, the sequencer state type and counter sizing.
// ----------------------------------------------------------------------------
package mexp_pkg;

   // width at which the base is taken as a two's complement value (8..64)
   localparam int DATA_WIDTH = 64;
   localparam int BASE_W     = 64;
   localparam int EXP_W      = 63;
   localparam int MOD_W      = 63;

   localparam int MAX_STEPS  = (DATA_WIDTH > MOD_W) ? DATA_WIDTH : MOD_W;
   localparam int CNT_W      = $clog2(MAX_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FIX,
      ST_NEXT,
      ST_MUL,
      ST_SQR,
      ST_FINISH
   } state_type;

endpackage : mexp_pkg
`default_nettype wire

// File: rtl/mexp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_req_if : request channel
// Valid/ready channel carrying base, exponent and modulus.
// ----------------------------------------------------------------------------
interface mexp_req_if;
   import mexp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [BASE_W-1:0] base_value;
   logic        [EXP_W-1:0]  exponent;
   logic        [MOD_W-1:0]  modulus;

   modport source (output valid, output base_value, output exponent, output modulus,
                   input ready);
   modport sink   (input valid, input base_value, input exponent, input modulus,
                   output ready);
endinterface : mexp_req_if
`default_nettype wire

// File: rtl/mexp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_rsp_if : response channel
// Valid/ready channel carrying the power residue.
// ----------------------------------------------------------------------------
interface mexp_rsp_if;
   import mexp_pkg::*;

   logic             valid;
   logic             ready;
   logic [MOD_W-1:0] power_residue;

   modport source (output valid, output power_residue, input ready);
   modport sink   (input valid, input power_residue, output ready);
endinterface : mexp_rsp_if
`default_nettype wire

// File: rtl/modular_exponentiation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation : base^exponent mod modulus, square and multiply
// Iterative design around one shared double-and-add modular step unit.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+----------------------------------------
//  req_if  | in  | valid & ready | base_value[64] s, exponent[63], modulus[63]
//  rsp_if  | out | valid & ready | power_residue[63]
//
//  Sequence: base reduction (ST_REDUCE, ST_FIX), then per exponent bit a
//  decision in ST_NEXT, one modular multiply (only for set bits) and one
//  squaring (skipped after the top set bit), each a bit-serial loop of the
//  shared step unit. Exponent zero or modulus zero go straight to finish.
//  Reset (synchronous) returns the sequencer to idle and drops rsp valid.
//  req ready is high only when idle; a finished word sits in the output
//  register, so a new word is taken while the last one waits on rsp.
//
module modular_exponentiation (
   input  wire logic   clock,
   input  wire logic   reset,
   mexp_req_if.sink    req_if,
   mexp_rsp_if.source  rsp_if
);
   import mexp_pkg::*;

   state_type             state_ff,  state_in;
   logic [EXP_W-1:0]      exp_ff,    exp_in;
   logic [MOD_W-1:0]      mod_ff,    mod_in;
   logic [MOD_W-1:0]      acc_ff,    acc_in;     // step unit accumulator
   logic [MOD_W-1:0]      res_ff,    res_in;     // running result
   logic [MOD_W-1:0]      base_ff,   base_in;    // running base power
   logic [MOD_W-1:0]      mult_ff,   mult_in;    // multiplier bits, msb first
   logic [DATA_WIDTH-1:0] mag_ff,    mag_in;     // base magnitude, msb first
   logic                  neg_ff,    neg_in;
   logic [CNT_W-1:0]      cnt_ff,    cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]      rsp_data_ff,  rsp_data_in;

   // --- shared step unit: (2*acc + addend) mod m, with acc, addend < m ---
   logic [MOD_W-1:0] addend;
   logic [MOD_W+1:0] sum_w, one_m_w, two_m_w, diff1_w, diff2_w;
   logic [MOD_W-1:0] step_out;

   assign sum_w   = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
   assign one_m_w = {2'b00, mod_ff};
   assign two_m_w = {1'b0, mod_ff, 1'b0};
   assign diff1_w = sum_w - one_m_w;
   assign diff2_w = sum_w - two_m_w;

   always_comb begin
      if (sum_w >= two_m_w) begin
         step_out = diff2_w[MOD_W-1:0];
      end else if (sum_w >= one_m_w) begin
         step_out = diff1_w[MOD_W-1:0];
      end else begin
         step_out = sum_w[MOD_W-1:0];
      end
   end

   // operand select: long division bit, or multiplicand gated by multiplier bit
   always_comb begin
      case (state_ff)
         ST_REDUCE: addend = {{(MOD_W-1){1'b0}}, mag_ff[DATA_WIDTH-1]};
         ST_MUL:    addend = mult_ff[MOD_W-1] ? res_ff  : '0;
         ST_SQR:    addend = mult_ff[MOD_W-1] ? base_ff : '0;
         default:   addend = '0;
      endcase
   end

   // --- request side ---
   logic                  req_take;
   logic [DATA_WIDTH-1:0] raw_base;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign raw_base     = req_if.base_value[DATA_WIDTH-1:0];

   // --- sequencer ---
   always_comb begin
      state_in    = state_ff;
      exp_in      = exp_ff;
      mod_in      = mod_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      base_in     = base_ff;
      mult_in     = mult_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               exp_in = req_if.exponent;
               mod_in = req_if.modulus;
               neg_in = raw_base[DATA_WIDTH-1];
               mag_in = raw_base[DATA_WIDTH-1] ? (~raw_base + 1'b1) : raw_base;
               acc_in = '0;
               cnt_in = CNT_W'(DATA_WIDTH - 1);
               if (req_if.exponent == '0) begin
                  res_in   = MOD_W'(1);
                  state_in = ST_FINISH;
               end else if (req_if.modulus == '0) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end

         ST_REDUCE: begin
            // restoring division, one dividend bit a cycle; remainder in acc
            acc_in = step_out;
            mag_in = {mag_ff[DATA_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIX;
            end
         end

         ST_FIX: begin
            // negative base: residue is m - r unless r is zero
            base_in  = (neg_ff && (acc_ff != '0)) ? (mod_ff - acc_ff) : acc_ff;
            res_in   = (mod_ff == MOD_W'(1)) ? '0 : MOD_W'(1);
            state_in = ST_NEXT;
         end

         ST_NEXT: begin
            acc_in  = '0;
            mult_in = base_ff;
            cnt_in  = CNT_W'(MOD_W - 1);
            state_in = exp_ff[0] ? ST_MUL : ST_SQR;
         end

         ST_MUL: begin
            acc_in  = step_out;
            mult_in = {mult_ff[MOD_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_in = step_out;
               if (exp_ff[EXP_W-1:1] == '0) begin
                  // top bit done, last squaring not needed
                  state_in = ST_FINISH;
               end else begin
                  acc_in   = '0;
                  mult_in  = base_ff;
                  cnt_in   = CNT_W'(MOD_W - 1);
                  state_in = ST_SQR;
               end
            end
         end

         ST_SQR: begin
            acc_in  = step_out;
            mult_in = {mult_ff[MOD_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               base_in  = step_out;
               exp_in   = {1'b0, exp_ff[EXP_W-1:1]};
               state_in = ST_NEXT;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      base_ff     <= base_in;
      mult_ff     <= mult_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.power_residue = rsp_data_ff;

   // --- checks ---
   // step unit accumulator stays a proper residue while iterating
   a_acc_below_mod: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE || state_ff == ST_MUL || state_ff == ST_SQR)
      |-> (acc_ff < mod_ff))
      else $error("accumulator not below modulus");

   // operands of the multiply loops are reduced
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL || state_ff == ST_SQR)
      |-> (res_ff < mod_ff) && (base_ff < mod_ff))
      else $error("multiply operand not reduced");

   // a new response word only ever comes from the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish state");

endmodule : modular_exponentiation
`default_nettype wire

// File: bench/tb_modular_exponentiation.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation : self-checking bench for the modexp block
// Sends base/exponent/modulus words with random source gaps and sink stalls.
// Every accepted word is predicted with a behavioural square-and-multiply.
// Each residue word is checked in order against the queue of predictions.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
   import mexp_pkg::*;

   // The run sends 103 words plus source gaps and sink stalls; the cap
   // sits well clear of the worst legal run.
   localparam int unsigned CYCLE_LIMIT  = 5_000_000;
   // Longest single word: base reduction, then 63 multiplies and 62 squarings.
   localparam int unsigned DRAIN_CYCLES = 8400;

   localparam logic [BASE_W-1:0] BASE_MIN = {1'b1, {(BASE_W-1){1'b0}}};
   localparam logic [BASE_W-1:0] BASE_MAX = {1'b0, {(BASE_W-1){1'b1}}};
   localparam logic [EXP_W-1:0]  EXP_MAX  = '1;
   localparam logic [MOD_W-1:0]  MOD_MAX  = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mexp_req_if req_if ();
   mexp_rsp_if rsp_if ();

   modular_exponentiation dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   // predicted residues, oldest first
   logic [MOD_W-1:0] residue_queue[$];
   int unsigned      error_count  = 0;
   int unsigned      cycle_count  = 0;
   int unsigned      stall_left   = 0;
   bit               src_gaps_on  = 1'b0;
   bit               sink_stalls_on = 1'b0;

   // ------------------------------------------------------------------------
   // Behavioural model
   // ------------------------------------------------------------------------

   // a * b mod m at full double width; a and b are already below m
   function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] m);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      wide = wide % {64'd0, m};
      return wide[63:0];
   endfunction

   function automatic logic [MOD_W-1:0] predict_residue(logic [BASE_W-1:0] base_raw,
                                                        logic [EXP_W-1:0]  exponent,
                                                        logic [MOD_W-1:0]  modulus);
      logic [63:0]      sign_bit;
      logic [63:0]      width_mask;
      logic [63:0]      taken;
      logic [63:0]      magnitude;
      logic [63:0]      m;
      logic [63:0]      square;
      logic [63:0]      acc;
      logic [EXP_W-1:0] e;
      // x^0 is 1 whatever the modulus, even 0 or 1
      if (exponent == '0)
         return MOD_W'(1);
      // no reduction possible with a zero modulus
      if (modulus == '0)
         return '0;
      m          = {1'b0, modulus};
      // base is seen as a DATA_WIDTH-bit two's complement value
      sign_bit   = 64'd1 << (DATA_WIDTH - 1);
      width_mask = (sign_bit << 1) - 64'd1;
      taken      = base_raw & width_mask;
      if ((taken & sign_bit) == '0) begin
         square = taken % m;
      end else begin
         // negative: reduce the magnitude, then fold back into 0..m-1
         magnitude = ((~taken) & width_mask) + 64'd1;
         square    = magnitude % m;
         if (square != '0)
            square = m - square;
      end
      acc = 64'd1 % m;
      e   = exponent;
      while (e != '0) begin
         if (e[0])
            acc = mod_product(acc, square, m);
         square = mod_product(square, square, m);
         e      = e >> 1;
      end
      return acc[MOD_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------------

   // mostly back to back, often a short pause, now and then a long one
   function automatic int unsigned draw_idle();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 80);
   endfunction

   function automatic logic [63:0] random_bits(int unsigned width);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (width < 64)
         v = v & ((64'd1 << width) - 64'd1);
      return v;
   endfunction

   function automatic logic [MOD_W-1:0] random_modulus();
      int unsigned pick;
      int unsigned width;
      logic [63:0] v;
      pick = $urandom_range(0, 39);
      if (pick == 0)
         return '0;                       // outside the legal range, still defined
      if (pick < 7)
         return MOD_W'($urandom_range(1, 7));   // tiny moduli, 1 included
      width = $urandom_range(2, MOD_W);
      v     = random_bits(width) | (64'd1 << (width - 1));
      return v[MOD_W-1:0];
   endfunction

   function automatic logic [BASE_W-1:0] random_base(logic [MOD_W-1:0] modulus);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         6: return BASE_W'($signed($urandom_range(0, 40)) - 20);  // small, either sign
         7: return -{1'b0, modulus};                      // negative multiple
         8: return {1'b0, modulus};                       // positive multiple
         9: return {1'b0, modulus} - 64'd1;               // largest residue
         default: return random_bits(BASE_W);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: one word per call, valid left high for the next word
   // ------------------------------------------------------------------------
   task automatic send_power_word(input logic [BASE_W-1:0] base_value,
                                  input logic [EXP_W-1:0]  exponent,
                                  input logic [MOD_W-1:0]  modulus);
      int unsigned idle;
      idle = src_gaps_on ? draw_idle() : 0;
      if (idle != 0) begin
         req_if.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.base_value <= base_value;
      req_if.exponent   <= exponent;
      req_if.modulus    <= modulus;
      do @(posedge clock); while (!req_if.ready);
      residue_queue.push_back(predict_residue(base_value, exponent, modulus));
   endtask

   // ------------------------------------------------------------------------
   // Response checker and sink stall generator
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (residue_queue.size() == 0) begin
            $display("%0t: unexpected residue word, expected none, actual %h",
                     $time, rsp_if.power_residue);
            error_count++;
         end else begin
            if (rsp_if.power_residue !== residue_queue[0]) begin
               $display("%0t: power_residue mismatch, expected %h, actual %h",
                        $time, residue_queue[0], rsp_if.power_residue);
               error_count++;
            end
            void'(residue_queue.pop_front());
         end
      end
      if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_if.ready  <= 1'b0;
      end else if (sink_stalls_on) begin
         int unsigned hold;
         hold = draw_idle();
         if (hold == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left   <= hold - 1;
         end
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Extremes and corner cases, no idling on either side.
   task automatic test_directed_corners();
      src_gaps_on    = 1'b0;
      sink_stalls_on <= 1'b0;
      // exponent zero gives 1 for every modulus, 0 and 1 included
      send_power_word(64'sd5, '0, 63'd1);
      send_power_word(-64'sd3, '0, '0);
      send_power_word(BASE_MIN, '0, MOD_MAX);
      send_power_word('0, '0, 63'd5);
      // zero modulus with a live exponent
      send_power_word(64'sd7, 63'd5, '0);
      send_power_word(-64'sd1, EXP_MAX, '0);
      // modulus one kills everything
      send_power_word(64'sd123, 63'd1, 63'd1);
      send_power_word(BASE_MIN, EXP_MAX, 63'd1);
      // base extremes against the largest modulus and the one below it
      send_power_word(BASE_MIN, 63'd1, MOD_MAX);
      send_power_word(BASE_MAX, 63'd1, MOD_MAX);
      send_power_word(BASE_MAX, EXP_MAX, MOD_MAX);
      send_power_word(BASE_MIN, EXP_MAX, MOD_MAX - 1);
      // negative bases, including a remainder of zero
      send_power_word(-64'sd1, 63'd2, MOD_MAX);
      send_power_word(-64'sd1, 63'd3, 63'd7);
      send_power_word(-64'sd7, 63'd1, 63'd5);
      send_power_word(-64'sd1000003, 63'd3, 63'd1000003);
      // zero base, an even modulus, long exponents
      send_power_word('0, EXP_MAX, 63'd13);
      send_power_word(64'sd3, EXP_MAX, 63'd2);
      send_power_word(64'sd2, 63'd62, MOD_MAX);
      // alternating bit patterns so every bit sees both values
      send_power_word(64'h5555_5555_5555_5555, 63'h5555_5555_5555_5555, MOD_MAX);
      send_power_word(64'hAAAA_AAAA_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA,
                      63'h5555_5555_5555_5555);
   endtask

   // Bulk random words with short exponents; idling on both sides.
   task automatic test_random_short_exponents(input int unsigned count);
      logic [MOD_W-1:0] modulus;
      logic [EXP_W-1:0] exponent;
      src_gaps_on    = 1'b1;
      sink_stalls_on <= 1'b1;
      repeat (count) begin
         modulus  = random_modulus();
         exponent = ($urandom_range(0, 15) == 0) ? '0
                  : EXP_W'(random_bits($urandom_range(1, 12)));
         send_power_word(random_base(modulus), exponent, modulus);
      end
   endtask

   // A handful of full width exponents; these set the run time.
   task automatic test_random_wide_exponents(input int unsigned count);
      logic [MOD_W-1:0] modulus;
      logic [EXP_W-1:0] exponent;
      src_gaps_on    = 1'b1;
      sink_stalls_on <= 1'b1;
      repeat (count) begin
         modulus  = random_modulus();
         exponent = EXP_W'(random_bits(EXP_W));
         if ($urandom_range(0, 1) == 0)
            exponent[EXP_W-1] = 1'b1;
         send_power_word(random_base(modulus), exponent, modulus);
      end
   endtask

   // Quick words back to back against a stalling sink: a new word is taken
   // while the previous residue is still held in the output register.
   task automatic test_output_backpressure(input int unsigned count);
      logic [MOD_W-1:0] modulus;
      logic [EXP_W-1:0] exponent;
      src_gaps_on    = 1'b0;
      sink_stalls_on <= 1'b1;
      repeat (count) begin
         modulus  = ($urandom_range(0, 2) == 0) ? '0 : random_modulus();
         exponent = ($urandom_range(0, 1) == 0) ? '0 : EXP_W'(random_bits(3));
         send_power_word(random_base(modulus), exponent, modulus);
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid      = 1'b0;
      req_if.base_value = '0;
      req_if.exponent   = '0;
      req_if.modulus    = '0;
      rsp_if.ready      = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_short_exponents(50);
      test_output_backpressure(12);
      test_random_wide_exponents(10);
      test_random_short_exponents(10);

      req_if.valid <= 1'b0;
      while (residue_queue.size() != 0) @(posedge clock);
      // let any stray extra word show up before closing
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule : tb_modular_exponentiation

// File: sim.f
rtl/mexp_pkg.sv
rtl/mexp_req_if.sv
rtl/mexp_rsp_if.sv
rtl/modular_exponentiation.sv
bench/tb_modular_exponentiation.sv
